FILE: rtl/lsbse_pkg.sv
// ----------------------------------------------------------------------------
// lsbse_pkg
// Shared types, codes and character mapping for the LSB stego embed/extract
// block.
// ----------------------------------------------------------------------------
package lsbse_pkg;

   localparam int DIM_W       = 10;
   localparam int KEY_W       = 9;
   localparam int BYTE_ADDR_W = 20;
   localparam int ROW_W       = 20;
   localparam int LIN_W       = 22;
   localparam int SYM_W       = 5;
   localparam int POS_W       = 3;

   localparam logic [POS_W-1:0] LAST_BIT = 3'd4;

   localparam logic [DIM_W-1:0] DIM_RESET = 10'd512;

   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic [1:0] CHAN_NONE = 2'd3;

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_PERIOD  = 8'h2E;
   localparam logic [7:0] CHAR_COMMA   = 8'h2C;

   localparam logic [SYM_W-1:0] CODE_LAST_LETTER = 5'd25;
   localparam logic [SYM_W-1:0] CODE_SPACE       = 5'd26;
   localparam logic [SYM_W-1:0] CODE_PERIOD      = 5'd27;
   localparam logic [SYM_W-1:0] CODE_OTHER       = 5'd28;

   typedef enum logic [1:0] {
      ACT_WRITE   = 2'd0,
      ACT_READ    = 2'd1,
      ACT_EMBED   = 2'd2,
      ACT_EXTRACT = 2'd3
   } action_type;

   typedef struct packed {
      logic [DIM_W-1:0] eff_width;
      logic [DIM_W-1:0] eff_height;
      logic [LIN_W-1:0] limit;
      logic             settled;
   } geom_type;

   function automatic logic [SYM_W-1:0] code_of_char(input logic [7:0] c);
      logic [7:0] diff;
      diff = c - CHAR_UPPER_A;
      if ((c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
          (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)) begin
         return diff[SYM_W-1:0];
      end else if (c == CHAR_SPACE) begin
         return CODE_SPACE;
      end else if (c == CHAR_PERIOD) begin
         return CODE_PERIOD;
      end
      return CODE_OTHER;
   endfunction

   function automatic logic [7:0] char_of_code(input logic [SYM_W-1:0] n);
      if (n <= CODE_LAST_LETTER) begin
         return CHAR_UPPER_A + {3'b000, n};
      end else if (n == CODE_SPACE) begin
         return CHAR_SPACE;
      end else if (n == CODE_PERIOD) begin
         return CHAR_PERIOD;
      end
      return CHAR_COMMA;
   endfunction

endpackage

FILE: rtl/lsbse_ifs.sv
// ----------------------------------------------------------------------------
// lsbse interfaces
// Valid/ready channels for request and response beats.
// ----------------------------------------------------------------------------
interface lsbse_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [19:0] byte_addr;
   logic [7:0] byte_data;
   logic [8:0] key_x;
   logic [8:0] key_y;
   logic [1:0] key_channel;
   logic [7:0] char_code;

   modport source (output valid, action, byte_addr, byte_data, key_x, key_y,
                   key_channel, char_code, input ready);
   modport sink (input valid, action, byte_addr, byte_data, key_x, key_y,
                 key_channel, char_code, output ready);
endinterface

interface lsbse_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic [7:0] symbol_char;
   logic       symbol_done;
   logic       out_of_range;

   modport source (output valid, read_data, symbol_char, symbol_done, out_of_range,
                   input ready);
   modport sink (input valid, read_data, symbol_char, symbol_done, out_of_range,
                 output ready);
endinterface

FILE: rtl/lsbse_store.sv
// ----------------------------------------------------------------------------
// lsbse_store
// Single-port synchronous image byte memory with registered read.
// ----------------------------------------------------------------------------
module lsbse_store #(
   parameter int DEPTH  = 786432,
   parameter int ADDR_W = 20
) (
   input  logic              clock,
   input  logic              en,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [7:0]        wdata,
   output logic [7:0]        rdata
);

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/lsbse_geom.sv
// ----------------------------------------------------------------------------
// lsbse_geom
// Picture size registers, clamped size and registered byte count of the
// picture; flags when the byte count has settled after a write.
// ----------------------------------------------------------------------------
module lsbse_geom #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic                    csr_index,
   input  logic [lsbse_pkg::DIM_W-1:0] csr_wdata,
   output lsbse_pkg::geom_type     geom
);

   logic [lsbse_pkg::DIM_W-1:0]   width_ff;
   logic [lsbse_pkg::DIM_W-1:0]   height_ff;
   logic [lsbse_pkg::DIM_W-1:0]   eff_width;
   logic [lsbse_pkg::DIM_W-1:0]   eff_height;
   logic [2*lsbse_pkg::DIM_W-1:0] area_in;
   logic [2*lsbse_pkg::DIM_W-1:0] area_ff;
   logic [lsbse_pkg::LIN_W-1:0]   limit_in;
   logic [lsbse_pkg::LIN_W-1:0]   limit_ff;
   logic [1:0]                    settle_ff;

   assign eff_width  = (32'(width_ff) > MAX_WIDTH) ?
                       lsbse_pkg::DIM_W'(MAX_WIDTH) : width_ff;
   assign eff_height = (32'(height_ff) > MAX_HEIGHT) ?
                       lsbse_pkg::DIM_W'(MAX_HEIGHT) : height_ff;

   assign area_in  = eff_width * eff_height;
   assign limit_in = {1'b0, area_ff, 1'b0} + {2'b00, area_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= lsbse_pkg::DIM_RESET;
         height_ff <= lsbse_pkg::DIM_RESET;
         settle_ff <= 2'd2;
      end else begin
         if (csr_we) begin
            settle_ff <= 2'd2;
            if (csr_index == lsbse_pkg::CSR_IMAGE_WIDTH) begin
               width_ff <= csr_wdata;
            end else begin
               height_ff <= csr_wdata;
            end
         end else if (settle_ff != 2'd0) begin
            settle_ff <= settle_ff - 2'd1;
         end
      end
      area_ff  <= area_in;
      limit_ff <= limit_in;
   end

   assign geom.eff_width  = eff_width;
   assign geom.eff_height = eff_height;
   assign geom.limit      = limit_ff;
   assign geom.settled    = (settle_ff == 2'd0);

endmodule

FILE: rtl/lsb_stego_embed_extract.sv
// ----------------------------------------------------------------------------
// lsb_stego_embed_extract
// Image byte store with LSB embed and extract of 5-bit character codes.
// ----------------------------------------------------------------------------
// Each request beat goes from acceptance through ST_MUL for the key row
// multiply and the range checks, ST_ADDR to address the image memory, and
// ST_DATA for its registered read data, the LSB write-back of an embed and
// the response. The block returns to idle once the response is registered and
// only then takes the next beat, so one beat is in flight at a time, set by
// the read-modify-write through the single memory port. A response waiting on
// rsp_if does not hold off the next request, but that beat then holds in its
// last cycle until the waiting response is taken. After a csr write the
// request channel stays not ready while the picture byte count settles.
// Image memory contents are undefined until written; there is no clearing
// pass.
// ----------------------------------------------------------------------------
module lsb_stego_embed_extract #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512
) (
   input  logic                        clock,
   input  logic                        reset,
   lsbse_req_if.sink                   req_if,
   lsbse_rsp_if.source                 rsp_if,
   input  logic                        csr_we,
   input  logic                        csr_index,
   input  logic [lsbse_pkg::DIM_W-1:0] csr_wdata
);

   localparam int STORE_DEPTH = 3 * MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADDR,
      ST_DATA
   } state_type;

   state_type                       state_ff;
   lsbse_pkg::geom_type             geom;

   lsbse_pkg::action_type           action_ff;
   logic [lsbse_pkg::BYTE_ADDR_W-1:0] byte_addr_ff;
   logic [7:0]                      byte_data_ff;
   logic [lsbse_pkg::KEY_W-1:0]     key_x_ff;
   logic [lsbse_pkg::KEY_W-1:0]     key_y_ff;
   logic [1:0]                      key_channel_ff;
   logic [7:0]                      char_code_ff;

   logic [lsbse_pkg::ROW_W-1:0]     rowmul_in;
   logic [lsbse_pkg::ROW_W-1:0]     rowmul_ff;
   logic                            oor_in;
   logic                            oor_ff;
   logic [ADDR_W-1:0]               addr_in;
   logic [ADDR_W-1:0]               addr_ff;

   logic [lsbse_pkg::POS_W-1:0]     bit_index_ff;
   logic [lsbse_pkg::SYM_W-1:0]     accum_ff;

   logic                            rsp_valid_ff;
   logic [7:0]                      read_data_ff;
   logic [7:0]                      symbol_char_ff;
   logic                            symbol_done_ff;
   logic                            out_of_range_ff;

   logic [lsbse_pkg::DIM_W-1:0]     row;
   logic [lsbse_pkg::ROW_W-1:0]     row_prod;
   logic                            byte_act;
   logic                            key_oor;
   logic                            byte_oor;
   logic [lsbse_pkg::LIN_W-1:0]     key_addr;
   logic [lsbse_pkg::LIN_W-1:0]     lin_addr;
   logic [31:0]                     lin_addr32;

   logic                            mem_en;
   logic                            mem_we;
   logic [ADDR_W-1:0]               mem_addr;
   logic [7:0]                      mem_wdata;
   logic [7:0]                      mem_rdata;

   logic                            accept;
   logic                            advance;
   logic                            key_hit;
   logic                            last;
   logic [lsbse_pkg::SYM_W-1:0]     code;
   logic                            embed_bit;
   logic [lsbse_pkg::SYM_W-1:0]     accum_in;
   logic                            writeback;

   lsbse_geom #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_geom (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .geom      (geom)
   );

   lsbse_store #(
      .DEPTH  (STORE_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock (clock),
      .en    (mem_en),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   assign req_if.ready = (state_ff == ST_IDLE) && geom.settled;
   assign accept       = req_if.valid && req_if.ready;

   assign byte_act = (action_ff == lsbse_pkg::ACT_WRITE) ||
                     (action_ff == lsbse_pkg::ACT_READ);

   // key row and range checks
   assign row       = geom.eff_height - lsbse_pkg::DIM_W'(1) - {1'b0, key_y_ff};
   assign row_prod  = row * geom.eff_width;
   assign rowmul_in = row_prod + {11'b0, key_x_ff};
   assign key_oor   = ({1'b0, key_x_ff} >= geom.eff_width) ||
                      ({1'b0, key_y_ff} >= geom.eff_height) ||
                      (key_channel_ff == lsbse_pkg::CHAN_NONE);
   assign byte_oor  = ({2'b00, byte_addr_ff} >= geom.limit);
   assign oor_in    = byte_act ? byte_oor : key_oor;

   // linear byte address
   assign key_addr   = {1'b0, rowmul_ff, 1'b0} + {2'b00, rowmul_ff} +
                       {20'b0, key_channel_ff};
   assign lin_addr   = byte_act ? {2'b00, byte_addr_ff} : key_addr;
   assign lin_addr32 = 32'(lin_addr);
   assign addr_in    = lin_addr32[ADDR_W-1:0];

   // symbol bit handling
   assign code      = lsbse_pkg::code_of_char(char_code_ff);
   assign embed_bit = code[bit_index_ff];
   assign accum_in  = accum_ff | (lsbse_pkg::SYM_W'(mem_rdata[0]) << bit_index_ff);
   assign last      = (bit_index_ff == lsbse_pkg::LAST_BIT);
   assign key_hit   = !byte_act && !oor_ff;

   assign advance   = (state_ff == ST_DATA) && (!rsp_valid_ff || rsp_if.ready);
   assign writeback = advance && key_hit && (action_ff == lsbse_pkg::ACT_EMBED);

   always_comb begin
      mem_en    = 1'b0;
      mem_we    = 1'b0;
      mem_addr  = addr_ff;
      mem_wdata = byte_data_ff;
      unique case (state_ff)
         ST_ADDR: begin
            mem_en   = !oor_ff;
            mem_we   = (action_ff == lsbse_pkg::ACT_WRITE);
            mem_addr = addr_in;
         end
         ST_DATA: begin
            mem_en    = writeback;
            mem_we    = writeback;
            mem_wdata = {mem_rdata[7:1], embed_bit};
         end
         default: begin
            mem_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bit_index_ff <= '0;
         accum_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               state_ff <= ST_ADDR;
            end
            ST_ADDR: begin
               state_ff <= ST_DATA;
            end
            ST_DATA: begin
               if (advance) begin
                  state_ff <= ST_IDLE;
                  if (key_hit) begin
                     if (last) begin
                        bit_index_ff <= '0;
                        accum_ff     <= '0;
                     end else begin
                        bit_index_ff <= bit_index_ff + lsbse_pkg::POS_W'(1);
                        if (action_ff == lsbse_pkg::ACT_EXTRACT) begin
                           accum_ff <= accum_in;
                        end
                     end
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase

         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      if (accept) begin
         action_ff      <= lsbse_pkg::action_type'(req_if.action);
         byte_addr_ff   <= req_if.byte_addr;
         byte_data_ff   <= req_if.byte_data;
         key_x_ff       <= req_if.key_x;
         key_y_ff       <= req_if.key_y;
         key_channel_ff <= req_if.key_channel;
         char_code_ff   <= req_if.char_code;
      end
      if (state_ff == ST_MUL) begin
         rowmul_ff <= rowmul_in;
         oor_ff    <= oor_in;
      end
      if (state_ff == ST_ADDR) begin
         addr_ff <= addr_in;
      end
      if (advance) begin
         read_data_ff    <= (action_ff == lsbse_pkg::ACT_READ && !oor_ff) ?
                            mem_rdata : 8'h00;
         symbol_char_ff  <= (key_hit && last && action_ff == lsbse_pkg::ACT_EXTRACT) ?
                            lsbse_pkg::char_of_code(accum_in) : 8'h00;
         symbol_done_ff  <= key_hit && last;
         out_of_range_ff <= oor_ff;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.read_data    = read_data_ff;
   assign rsp_if.symbol_char  = symbol_char_ff;
   assign rsp_if.symbol_done  = symbol_done_ff;
   assign rsp_if.out_of_range = out_of_range_ff;

endmodule

FILE: rtl/lsbse_checker.sv
// ----------------------------------------------------------------------------
// lsbse_checker
// Port-level checks on the LSB stego embed/extract block.
// ----------------------------------------------------------------------------
module lsbse_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] read_data,
   input logic [7:0] symbol_char,
   input logic       symbol_done,
   input logic       out_of_range,
   input logic       csr_we
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_data) &&
      $stable(symbol_char) && $stable(symbol_done) && $stable(out_of_range))
      else $error("response beat changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous beat in flight");

   a_done_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(symbol_done && out_of_range))
      else $error("symbol completed on out-of-range key");

   a_read_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (read_data != 8'h00) |-> (symbol_char == 8'h00) && !symbol_done)
      else $error("byte read mixed with symbol result");

   a_settle_after_csr: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !req_ready)
      else $error("request ready before picture size settled");

endmodule

bind lsb_stego_embed_extract lsbse_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_if.valid),
   .req_ready    (req_if.ready),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .read_data    (rsp_if.read_data),
   .symbol_char  (rsp_if.symbol_char),
   .symbol_done  (rsp_if.symbol_done),
   .out_of_range (rsp_if.out_of_range),
   .csr_we       (csr_we)
);
